/* rtl/lng_pkg.sv */
// ----------------------------------------------------------------------------
// Lookahead noise gate package
// Shared constants, register indexes, control word layout and the microcode.
// ----------------------------------------------------------------------------
package lng_pkg;

  localparam int MAX_LOOKAHEAD_DEF = 4096;
  localparam int SAMPLE_BITS_DEF   = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int THR_W      = 16;
  localparam int COEFF_W    = 16;
  localparam int HOLDSET_W  = 24;
  localparam int HOLD_W     = 25;
  localparam int LOOK_W     = 13;
  localparam int GAIN_W     = 16;
  localparam int DELTA_W    = 17;

  localparam logic [GAIN_W-1:0] UNITY_GAIN = 16'h8000;
  localparam logic [HOLD_W-1:0] HOLD_MAX   = 25'h1FF_FFFF;

  localparam logic [THR_W-1:0]     OPEN_THR_RST  = 16'd32;
  localparam logic [THR_W-1:0]     CLOSE_THR_RST = 16'd16;
  localparam logic [COEFF_W-1:0]   ATTACK_RST    = 16'h8000;
  localparam logic [COEFF_W-1:0]   RELEASE_RST   = 16'h8000;
  localparam logic [HOLDSET_W-1:0] HOLD_SET_RST  = 24'd0;
  localparam logic [LOOK_W-1:0]    LOOK_RST      = 13'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OPEN_THR  = 3'd0,
    REG_CLOSE_THR = 3'd1,
    REG_ATTACK    = 3'd2,
    REG_RELEASE   = 3'd3,
    REG_HOLD      = 3'd4,
    REG_LOOKAHEAD = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [THR_W-1:0]     open_thr;
    logic [THR_W-1:0]     close_thr;
    logic [COEFF_W-1:0]   attack_coeff;
    logic [COEFF_W-1:0]   release_coeff;
    logic [HOLDSET_W-1:0] hold_samples;
    logic [LOOK_W-1:0]    lookahead_len;
  } cfg_t;

  localparam int STEP_W = 3;

  localparam logic [STEP_W-1:0] STEP_ACCEPT   = 3'd0;
  localparam logic [STEP_W-1:0] STEP_GAIN_MUL = 3'd1;
  localparam logic [STEP_W-1:0] STEP_GAIN_UPD = 3'd2;
  localparam logic [STEP_W-1:0] STEP_OUT_MUL  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_OUT_LOAD = 3'd4;

  typedef enum logic [1:0] {
    COND_NONE     = 2'd0,
    COND_WAIT_IN  = 2'd1,
    COND_WAIT_OUT = 2'd2
  } cond_t;

  typedef enum logic {
    MUL_GAIN = 1'b0,
    MUL_OUT  = 1'b1
  } mul_sel_t;

  typedef struct packed {
    cond_t             cond;
    logic [STEP_W-1:0] jump_to;
    logic              done;
    logic              accept;
    logic              mul_en;
    mul_sel_t          mul_sel;
    logic              mem_wr;
    logic              gain_upd;
    logic              out_load;
  } ctrl_t;

  typedef struct packed {
    logic in_avail;
    logic out_blocked;
  } status_t;

  // The control program. A step whose condition holds jumps to jump_to;
  // otherwise it moves on, back to the first step when done is set.
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = '{cond: COND_NONE, jump_to: STEP_ACCEPT, done: 1'b0, accept: 1'b0,
          mul_en: 1'b0, mul_sel: MUL_GAIN, mem_wr: 1'b0, gain_upd: 1'b0,
          out_load: 1'b0};
    case (step)
      STEP_ACCEPT: begin
        w.cond    = COND_WAIT_IN;
        w.jump_to = STEP_ACCEPT;
        w.accept  = 1'b1;
      end
      STEP_GAIN_MUL: begin
        w.mul_en  = 1'b1;
        w.mul_sel = MUL_GAIN;
        w.mem_wr  = 1'b1;
      end
      STEP_GAIN_UPD: begin
        w.gain_upd = 1'b1;
      end
      STEP_OUT_MUL: begin
        w.mul_en  = 1'b1;
        w.mul_sel = MUL_OUT;
      end
      STEP_OUT_LOAD: begin
        w.cond     = COND_WAIT_OUT;
        w.jump_to  = STEP_OUT_LOAD;
        w.out_load = 1'b1;
        w.done     = 1'b1;
      end
      default: begin
        w.done = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

/* rtl/lookahead_noise_gate_top.sv */
// ----------------------------------------------------------------------------
// Lookahead noise gate top level
// Noise gate with hysteresis, hold time, smoothed gain and a lookahead delay.
// ----------------------------------------------------------------------------
// Flow: a sample beat is taken in the accept step and its result beat is
//   loaded into the output register in the last step of the control program.
// The five-step control program takes no new sample until the last one has
//   loaded its result beat; a held result beat stalls that load.
// Reset: synchronous on rst; the gate closes, gain and counters clear, and the
//   delay line reads as zero until filled. Input also stalls during reset.
// ----------------------------------------------------------------------------
module lookahead_noise_gate_top #(
  parameter int MAX_LOOKAHEAD = lng_pkg::MAX_LOOKAHEAD_DEF,
  parameter int SAMPLE_BITS   = lng_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lng_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lng_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [SAMPLE_BITS-1:0]     sample_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [SAMPLE_BITS-1:0]     sample_out,
  output logic [lng_pkg::GAIN_W-1:0]        gain_now,
  output logic                              gate_is_open,
  output logic                              opened_now
);

  // The configuration registers live here. The port is always ready; writes
  // are expected only while no sample is in flight, so the datapath reads the
  // registers directly without any shadow copy.
  lng_pkg::cfg_t    cfg;
  lng_pkg::ctrl_t   ctrl;
  lng_pkg::status_t status;

  logic signed [SAMPLE_BITS-1:0] wr_data;
  logic signed [SAMPLE_BITS-1:0] tap_data;
  logic                          tap_written;
  logic                          tap_zero_len;

  assign cfg_ready = 1'b1;

  // Writes beyond the register list are accepted and dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.open_thr      <= lng_pkg::OPEN_THR_RST;
      cfg.close_thr     <= lng_pkg::CLOSE_THR_RST;
      cfg.attack_coeff  <= lng_pkg::ATTACK_RST;
      cfg.release_coeff <= lng_pkg::RELEASE_RST;
      cfg.hold_samples  <= lng_pkg::HOLD_SET_RST;
      cfg.lookahead_len <= lng_pkg::LOOK_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (lng_pkg::reg_idx_t'(cfg_index))
        lng_pkg::REG_OPEN_THR:  cfg.open_thr      <= cfg_data[lng_pkg::THR_W-1:0];
        lng_pkg::REG_CLOSE_THR: cfg.close_thr     <= cfg_data[lng_pkg::THR_W-1:0];
        lng_pkg::REG_ATTACK:    cfg.attack_coeff  <= cfg_data[lng_pkg::COEFF_W-1:0];
        lng_pkg::REG_RELEASE:   cfg.release_coeff <= cfg_data[lng_pkg::COEFF_W-1:0];
        lng_pkg::REG_HOLD:      cfg.hold_samples  <= cfg_data[lng_pkg::HOLDSET_W-1:0];
        lng_pkg::REG_LOOKAHEAD: cfg.lookahead_len <= cfg_data[lng_pkg::LOOK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The sequencer steps through the control program: take a sample and run
  // the detector, multiply for the gain step while the delay line is written,
  // update the gain, multiply the delayed sample by the gain, then load the
  // output register, waiting there while a previous beat is still held.
  lng_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  // The delay line is read at the accept edge and written afterwards in the gain
  // multiply step, so a full-depth lookahead returns the old sample before it is overwritten.
  lng_delay #(
    .MAX_LOOKAHEAD (MAX_LOOKAHEAD),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_delay (
    .clk           (clk),
    .rst           (rst),
    .lookahead_len (cfg.lookahead_len),
    .wr_en         (ctrl.mem_wr),
    .wr_data       (wr_data),
    .tap_data      (tap_data),
    .tap_written   (tap_written),
    .tap_zero_len  (tap_zero_len)
  );

  lng_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .ctrl         (ctrl),
    .status       (status),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample_in    (sample_in),
    .wr_data      (wr_data),
    .tap_data     (tap_data),
    .tap_written  (tap_written),
    .tap_zero_len (tap_zero_len),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sample_out   (sample_out),
    .gain_now     (gain_now),
    .gate_is_open (gate_is_open),
    .opened_now   (opened_now)
  );

endmodule

/* rtl/lng_sequencer.sv */
// ----------------------------------------------------------------------------
// Lookahead noise gate sequencer
// Step counter over the microcode table, with conditional wait jumps.
// ----------------------------------------------------------------------------
module lng_sequencer (
  input  logic             clk,
  input  logic             rst,
  input  lng_pkg::status_t status,
  output lng_pkg::ctrl_t   ctrl
);

  logic [lng_pkg::STEP_W-1:0] step;
  logic [lng_pkg::STEP_W-1:0] step_next;
  logic                       cond_true;

  assign ctrl = lng_pkg::ucode(step);

  always_comb begin
    case (ctrl.cond)
      lng_pkg::COND_WAIT_IN:  cond_true = !status.in_avail;
      lng_pkg::COND_WAIT_OUT: cond_true = status.out_blocked;
      default:                cond_true = 1'b0;
    endcase
  end

  always_comb begin
    if (cond_true) begin
      step_next = ctrl.jump_to;
    end else if (ctrl.done) begin
      step_next = lng_pkg::STEP_ACCEPT;
    end else begin
      step_next = step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= lng_pkg::STEP_ACCEPT;
    end else begin
      step <= step_next;
    end
  end

endmodule

/* rtl/lng_delay.sv */
// ----------------------------------------------------------------------------
// Lookahead noise gate delay line
// Circular sample memory with a write slot and a fill count.
// ----------------------------------------------------------------------------
module lng_delay #(
  parameter int MAX_LOOKAHEAD = lng_pkg::MAX_LOOKAHEAD_DEF,
  parameter int SAMPLE_BITS   = lng_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [lng_pkg::LOOK_W-1:0]    lookahead_len,
  input  logic                          wr_en,
  input  logic signed [SAMPLE_BITS-1:0] wr_data,
  output logic signed [SAMPLE_BITS-1:0] tap_data,
  output logic                          tap_written,
  output logic                          tap_zero_len
);

  localparam int AW  = (MAX_LOOKAHEAD > 1) ? $clog2(MAX_LOOKAHEAD) : 1;
  localparam int LW  = $clog2(MAX_LOOKAHEAD + 1);
  localparam int LAW = (LW > lng_pkg::LOOK_W) ? LW : lng_pkg::LOOK_W;

  logic signed [SAMPLE_BITS-1:0] mem [MAX_LOOKAHEAD];
  logic [AW-1:0] slot;
  logic [LW-1:0] fill;
  logic [LW-1:0] len_c;
  logic [LW:0]   rd_dist;
  logic [LW:0]   dist_wrap;
  logic [AW-1:0] rd_addr;

  // Lengths beyond the store saturate at its depth.
  always_comb begin
    if (LAW'(lookahead_len) > LAW'(MAX_LOOKAHEAD)) begin
      len_c = LW'(MAX_LOOKAHEAD);
    end else begin
      len_c = LW'(lookahead_len);
    end
    rd_dist = (LW + 1)'(slot) + (LW + 1)'(MAX_LOOKAHEAD) - (LW + 1)'(len_c);
    if (rd_dist >= (LW + 1)'(MAX_LOOKAHEAD)) begin
      dist_wrap = rd_dist - (LW + 1)'(MAX_LOOKAHEAD);
    end else begin
      dist_wrap = rd_dist;
    end
    rd_addr = dist_wrap[AW-1:0];
  end

  always_ff @(posedge clk) begin
    tap_data <= mem[rd_addr];
    if (wr_en) begin
      mem[slot] <= wr_data;
    end
  end

  // Slots are filled in order from zero, so a tap is valid once the fill
  // count reaches its distance; an unwritten tap is replaced by zero in the datapath.
  always_ff @(posedge clk) begin
    tap_written  <= (len_c <= fill);
    tap_zero_len <= (len_c == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
      fill <= '0;
    end else if (wr_en) begin
      if (slot == AW'(MAX_LOOKAHEAD - 1)) begin
        slot <= '0;
      end else begin
        slot <= slot + 1'b1;
      end
      if (fill != LW'(MAX_LOOKAHEAD)) begin
        fill <= fill + 1'b1;
      end
    end
  end

endmodule

/* rtl/lng_datapath.sv */
// ----------------------------------------------------------------------------
// Lookahead noise gate datapath
// Detector, hold counter, gain smoothing, shared multiplier and output beat.
// ----------------------------------------------------------------------------
module lng_datapath #(
  parameter int SAMPLE_BITS = lng_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lng_pkg::cfg_t                 cfg,
  input  lng_pkg::ctrl_t                ctrl,
  output lng_pkg::status_t              status,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic signed [SAMPLE_BITS-1:0] wr_data,
  input  logic signed [SAMPLE_BITS-1:0] tap_data,
  input  logic                          tap_written,
  input  logic                          tap_zero_len,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] sample_out,
  output logic [lng_pkg::GAIN_W-1:0]    gain_now,
  output logic                          gate_is_open,
  output logic                          opened_now
);

  localparam int CW = (SAMPLE_BITS > lng_pkg::THR_W) ? SAMPLE_BITS : lng_pkg::THR_W;
  localparam int MA = (SAMPLE_BITS > lng_pkg::DELTA_W) ? SAMPLE_BITS : lng_pkg::DELTA_W;
  localparam int PW = MA + lng_pkg::DELTA_W;
  localparam int YW = PW - 15;
  localparam int SW = 19;

  logic accept;
  logic out_load;

  logic [SAMPLE_BITS-1:0]       mag;
  logic                         gate, gate_next;
  logic [lng_pkg::HOLD_W-1:0]   hold, hold_next, hold_inc;
  logic                         opened, opened_next;
  logic [lng_pkg::GAIN_W-1:0]   gain;
  logic [lng_pkg::COEFF_W-1:0]  coeff, coeff_next;
  logic signed [lng_pkg::DELTA_W-1:0] delta, delta_next;
  logic signed [SAMPLE_BITS-1:0] delayed;

  logic signed [MA-1:0]              mul_a;
  logic signed [lng_pkg::DELTA_W-1:0] mul_b;
  logic signed [PW-1:0]              prod;
  logic signed [PW-1:0]              preg;

  logic signed [SW-1:0] step;
  logic signed [SW-1:0] gain_sum;
  logic [lng_pkg::GAIN_W-1:0] gain_next;
  logic signed [YW-1:0] y_full;
  logic signed [YW-1:0] y_hi, y_lo;
  logic signed [SAMPLE_BITS-1:0] y_sat;

  // The input stalls during reset so that no beat is taken and dropped there.
  assign in_stall        = rst || !ctrl.accept;
  assign accept          = in_valid && !in_stall;
  assign status.in_avail = in_valid;
  assign status.out_blocked = out_valid && out_stall;
  assign out_load        = ctrl.out_load && !status.out_blocked;

  // Detector with hysteresis and hold, evaluated on the arriving sample.
  always_comb begin
    mag         = sample_in[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample_in) : sample_in;
    hold_inc    = (hold != lng_pkg::HOLD_MAX) ? hold + 1'b1 : hold;
    gate_next   = gate;
    hold_next   = hold;
    opened_next = 1'b0;
    if (gate) begin
      if (CW'(mag) < CW'(cfg.close_thr)) begin
        hold_next = hold_inc;
        if (hold_inc > {1'b0, cfg.hold_samples}) begin
          gate_next = 1'b0;
        end
      end else begin
        hold_next = '0;
      end
    end else if (CW'(mag) >= CW'(cfg.open_thr)) begin
      gate_next   = 1'b1;
      hold_next   = '0;
      opened_next = 1'b1;
    end
    if (gate_next && (gain < lng_pkg::UNITY_GAIN)) begin
      coeff_next = cfg.attack_coeff;
    end else begin
      coeff_next = cfg.release_coeff;
    end
    if (gate_next) begin
      delta_next = $signed({1'b0, lng_pkg::UNITY_GAIN}) - $signed({1'b0, gain});
    end else begin
      delta_next = -$signed({1'b0, gain});
    end
  end

  // One multiplier serves both the gain step and the output product.
  always_comb begin
    if (ctrl.mul_sel == lng_pkg::MUL_OUT) begin
      mul_a = MA'(delayed);
      mul_b = $signed({1'b0, gain});
    end else begin
      mul_a = MA'($signed({1'b0, coeff}));
      mul_b = delta;
    end
    prod = mul_a * mul_b;
  end

  // Gain step rounds away from zero, then the gain is clamped to 0..unity.
  always_comb begin
    if (preg[PW-1]) begin
      step = SW'(preg >>> 15);
    end else begin
      step = SW'((preg + PW'(32767)) >>> 15);
    end
    gain_sum = $signed({{(SW - lng_pkg::GAIN_W){1'b0}}, gain}) + step;
    if (gain_sum < 0) begin
      gain_next = '0;
    end else if (gain_sum > $signed(SW'(lng_pkg::UNITY_GAIN))) begin
      gain_next = lng_pkg::UNITY_GAIN;
    end else begin
      gain_next = gain_sum[lng_pkg::GAIN_W-1:0];
    end
  end

  // Output product rounds to nearest, ties up, and saturates.
  always_comb begin
    y_full = YW'((preg + PW'(16384)) >>> 15);
    y_hi   = $signed({{(YW - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}});
    y_lo   = $signed({{(YW - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}});
    if (y_full > y_hi) begin
      y_sat = y_hi[SAMPLE_BITS-1:0];
    end else if (y_full < y_lo) begin
      y_sat = y_lo[SAMPLE_BITS-1:0];
    end else begin
      y_sat = y_full[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gate   <= 1'b0;
      hold   <= '0;
      opened <= 1'b0;
      gain   <= '0;
    end else begin
      if (accept) begin
        gate   <= gate_next;
        hold   <= hold_next;
        opened <= opened_next;
      end
      if (ctrl.gain_upd) begin
        gain <= gain_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      wr_data <= sample_in;
      coeff   <= coeff_next;
      delta   <= delta_next;
    end
    if (ctrl.mem_wr) begin
      if (tap_zero_len) begin
        delayed <= wr_data;
      end else if (tap_written) begin
        delayed <= tap_data;
      end else begin
        delayed <= '0;
      end
    end
    if (ctrl.mul_en) begin
      preg <= prod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sample_out   <= y_sat;
      gain_now     <= gain;
      gate_is_open <= gate;
      opened_now   <= opened;
    end
  end

endmodule

/* rtl/lng_checker.sv */
// ----------------------------------------------------------------------------
// Lookahead noise gate checker
// Port-level assertions on the top level, attached by a bind statement.
// ----------------------------------------------------------------------------
module lng_checker #(
  parameter int SAMPLE_BITS = lng_pkg::SAMPLE_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [SAMPLE_BITS-1:0] sample_out,
  input logic [lng_pkg::GAIN_W-1:0]    gain_now
);

  // No result beat is pending right after reset.
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // The input stalls in the cycle after a sample beat is taken.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken on back-to-back cycles");

  // A fresh result beat must trace back to an accepted sample beat.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 5))
    else $error("result beat without a matching sample beat");

  // A stalled result beat is held unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(sample_out) && $stable(gain_now)))
    else $error("stalled result beat changed");

endmodule

bind lookahead_noise_gate_top lng_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_lng_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .sample_out (sample_out),
  .gain_now   (gain_now)
);

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Lookahead noise gate testbench
// Drives audio sample beats into the gate, retunes its registers between
// bursts of traffic and checks every result beat against a cycle-free model
// of the gate kept inside this bench or a result typed into the directed plan.
// ----------------------------------------------------------------------------
module tb;

  // Model widths and limits of the gate as seen from its ports.
  localparam int          FULL_GAIN     = 32768;
  localparam int          DELAY_DEPTH   = 4096;
  localparam logic [24:0] HOLD_CEIL     = 25'h1FF_FFFF;
  localparam int          RANDOM_PHASES = 8;
  localparam int          PHASE_ITEMS   = 238;
  localparam int          CYCLE_LIMIT   = 500000;
  localparam int          DRAIN_CYCLES  = 10;

  // One result beat of the gate.
  typedef struct packed {
    logic signed [15:0] sample_out;
    logic [15:0]        gain;
    logic               gate_open;
    logic               just_opened;
  } gate_result_t;

  // A row of the directed plan either writes a register, sends a sample whose
  // result is typed in here, or sends a sample left to the model.
  typedef enum logic [1:0] {
    ROW_REG,
    ROW_CHECKED,
    ROW_PREDICTED
  } row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    lng_pkg::reg_idx_t   reg_sel;
    logic [23:0]         reg_val;
    logic signed [15:0]  smp;
    logic signed [15:0]  want_out;
    logic [15:0]         want_gain;
    logic                want_open;
    logic                want_opened;
  } plan_row_t;

  // The directed plan starts from the reset settings: thresholds 32 and 16,
  // both coefficients at unity (so the gain jumps straight to its target) and
  // no hold, which keeps the typed-in results easy to read off by hand.
  localparam plan_row_t DIRECTED [41] = '{
    // Closed gate on silence.
    '{ROW_CHECKED, lng_pkg::REG_OPEN_THR, 24'd0, 16'sd0, 16'sd0, 16'h0000, 1'b0, 1'b0},
    // Exactly at the open threshold: the gate opens and passes the sample.
    '{ROW_CHECKED, lng_pkg::REG_OPEN_THR, 24'd0, 16'sd32, 16'sd32, 16'h8000, 1'b1, 1'b1},
    // Full-scale positive and negative samples at unity gain.
    '{ROW_CHECKED, lng_pkg::REG_OPEN_THR, 24'd0, 16'sd32767, 16'sd32767, 16'h8000, 1'b1,
      1'b0},
    '{ROW_CHECKED, lng_pkg::REG_OPEN_THR, 24'd0, 16'sh8000, 16'sh8000, 16'h8000, 1'b1, 1'b0},
    // One sample under the close threshold closes at once with no hold.
    '{ROW_CHECKED, lng_pkg::REG_OPEN_THR, 24'd0, 16'sd15, 16'sd0, 16'h0000, 1'b0, 1'b0},
    // A negative sample opens on its magnitude.
    '{ROW_CHECKED, lng_pkg::REG_OPEN_THR, 24'd0, -16'sd32, -16'sd32, 16'h8000, 1'b1, 1'b1},
    // Exactly at the close threshold does not count toward closing.
    '{ROW_CHECKED, lng_pkg::REG_OPEN_THR, 24'd0, 16'sd16, 16'sd16, 16'h8000, 1'b1, 1'b0},
    '{ROW_CHECKED, lng_pkg::REG_OPEN_THR, 24'd0, -16'sd1, 16'sd0, 16'h0000, 1'b0, 1'b0},
    // Open threshold of zero: a closed gate opens even on silence.
    '{ROW_REG, lng_pkg::REG_OPEN_THR, 24'd0, 16'sd0, 16'sd0, 16'h0000, 1'b0, 1'b0},
    '{ROW_CHECKED, lng_pkg::REG_OPEN_THR, 24'd0, 16'sd0, 16'sd0, 16'h8000, 1'b1, 1'b1},
    // Close threshold of zero: nothing ever counts toward closing.
    '{ROW_REG, lng_pkg::REG_CLOSE_THR, 24'd0, 16'sd0, 16'sd0, 16'h0000, 1'b0, 1'b0},
    '{ROW_CHECKED, lng_pkg::REG_OPEN_THR, 24'd0, 16'sd1, 16'sd1, 16'h8000, 1'b1, 1'b0},
    // Both thresholds at their top: only the most negative sample reaches them.
    '{ROW_REG, lng_pkg::REG_OPEN_THR, 24'h8000, 16'sd0, 16'sd0, 16'h0000, 1'b0, 1'b0},
    '{ROW_REG, lng_pkg::REG_CLOSE_THR, 24'h8000, 16'sd0, 16'sd0, 16'h0000, 1'b0, 1'b0},
    '{ROW_CHECKED, lng_pkg::REG_OPEN_THR, 24'd0, 16'sd32767, 16'sd0, 16'h0000, 1'b0, 1'b0},
    '{ROW_CHECKED, lng_pkg::REG_OPEN_THR, 24'd0, 16'sd32767, 16'sd0, 16'h0000, 1'b0, 1'b0},
    '{ROW_CHECKED, lng_pkg::REG_OPEN_THR, 24'd0, 16'sh8000, 16'sh8000, 16'h8000, 1'b1, 1'b1},
    '{ROW_CHECKED, lng_pkg::REG_OPEN_THR, 24'd0, 16'sh8000, 16'sh8000, 16'h8000, 1'b1, 1'b0},
    // Slowest smoothing and a hold of two samples.
    '{ROW_REG, lng_pkg::REG_OPEN_THR, 24'd100, 16'sd0, 16'sd0, 16'h0000, 1'b0, 1'b0},
    '{ROW_REG, lng_pkg::REG_CLOSE_THR, 24'd50, 16'sd0, 16'sd0, 16'h0000, 1'b0, 1'b0},
    '{ROW_REG, lng_pkg::REG_HOLD, 24'd2, 16'sd0, 16'sd0, 16'h0000, 1'b0, 1'b0},
    '{ROW_REG, lng_pkg::REG_ATTACK, 24'd1, 16'sd0, 16'sd0, 16'h0000, 1'b0, 1'b0},
    '{ROW_REG, lng_pkg::REG_RELEASE, 24'd1, 16'sd0, 16'sd0, 16'h0000, 1'b0, 1'b0},
    '{ROW_PREDICTED, lng_pkg::REG_OPEN_THR, 24'd0, 16'sd1000, 16'sd0, 16'h0000, 1'b0, 1'b0},
    '{ROW_PREDICTED, lng_pkg::REG_OPEN_THR, 24'd0, 16'sd1000, 16'sd0, 16'h0000, 1'b0, 1'b0},
    '{ROW_PREDICTED, lng_pkg::REG_OPEN_THR, 24'd0, 16'sd10, 16'sd0, 16'h0000, 1'b0, 1'b0},
    '{ROW_PREDICTED, lng_pkg::REG_OPEN_THR, 24'd0, 16'sd10, 16'sd0, 16'h0000, 1'b0, 1'b0},
    '{ROW_PREDICTED, lng_pkg::REG_OPEN_THR, 24'd0, 16'sd10, 16'sd0, 16'h0000, 1'b0, 1'b0},
    // A zero attack freezes a rising gain; an oversized release overshoots
    // below zero and must be clamped.
    '{ROW_REG, lng_pkg::REG_ATTACK, 24'd0, 16'sd0, 16'sd0, 16'h0000, 1'b0, 1'b0},
    '{ROW_REG, lng_pkg::REG_RELEASE, 24'hFFFF, 16'sd0, 16'sd0, 16'h0000, 1'b0, 1'b0},
    '{ROW_PREDICTED, lng_pkg::REG_OPEN_THR, 24'd0, 16'sd1000, 16'sd0, 16'h0000, 1'b0, 1'b0},
    '{ROW_PREDICTED, lng_pkg::REG_OPEN_THR, 24'd0, 16'sd10, 16'sd0, 16'h0000, 1'b0, 1'b0},
    '{ROW_PREDICTED, lng_pkg::REG_OPEN_THR, 24'd0, 16'sd10, 16'sd0, 16'h0000, 1'b0, 1'b0},
    '{ROW_PREDICTED, lng_pkg::REG_OPEN_THR, 24'd0, 16'sd10, 16'sd0, 16'h0000, 1'b0, 1'b0},
    // Shortest lookahead, then the largest register value, far past the delay
    // line's depth, which saturates.
    '{ROW_REG, lng_pkg::REG_LOOKAHEAD, 24'd1, 16'sd0, 16'sd0, 16'h0000, 1'b0, 1'b0},
    '{ROW_REG, lng_pkg::REG_ATTACK, 24'h8000, 16'sd0, 16'sd0, 16'h0000, 1'b0, 1'b0},
    '{ROW_REG, lng_pkg::REG_RELEASE, 24'h8000, 16'sd0, 16'sd0, 16'h0000, 1'b0, 1'b0},
    '{ROW_PREDICTED, lng_pkg::REG_OPEN_THR, 24'd0, 16'sd500, 16'sd0, 16'h0000, 1'b0, 1'b0},
    '{ROW_PREDICTED, lng_pkg::REG_OPEN_THR, 24'd0, -16'sd700, 16'sd0, 16'h0000, 1'b0, 1'b0},
    '{ROW_REG, lng_pkg::REG_LOOKAHEAD, 24'h1FFF, 16'sd0, 16'sd0, 16'h0000, 1'b0, 1'b0},
    '{ROW_PREDICTED, lng_pkg::REG_OPEN_THR, 24'd0, 16'sd3000, 16'sd0, 16'h0000, 1'b0, 1'b0}
  };

  // Clock, reset and every block input start at known values.
  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               cfg_valid = 1'b0;
  logic [2:0]         cfg_index = lng_pkg::REG_OPEN_THR;
  logic [23:0]        cfg_data  = '0;
  logic               in_valid  = 1'b0;
  logic signed [15:0] sample_in = '0;
  logic               out_stall = 1'b0;
  logic               cfg_ready;
  logic               in_stall;
  logic               out_valid;
  logic signed [15:0] sample_out;
  logic [15:0]        gain_now;
  logic               gate_is_open;
  logic               opened_now;

  always #5 clk = ~clk;

  lookahead_noise_gate_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample_in    (sample_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sample_out   (sample_out),
    .gain_now     (gain_now),
    .gate_is_open (gate_is_open),
    .opened_now   (opened_now)
  );

  // Register copy held by the gate model.
  logic [15:0] thr_open   = 16'd32;
  logic [15:0] thr_close  = 16'd16;
  logic [15:0] coeff_att  = 16'h8000;
  logic [15:0] coeff_rel  = 16'h8000;
  logic [23:0] hold_set   = '0;
  logic [12:0] look_len   = '0;

  // Gate state held by the model, cleared as the block clears it at reset.
  logic signed [15:0] delay_line [DELAY_DEPTH];
  logic [11:0]        wr_slot    = '0;
  logic               gate_state = 1'b0;
  logic [24:0]        hold_cnt   = '0;
  int                 gain_q15   = 0;

  gate_result_t gate_results_q [$];

  int  errors          = 0;
  int  samples_sent    = 0;
  int  results_checked = 0;
  int  reg_writes      = 0;
  int  opens_seen      = 0;
  int  cycles          = 0;
  int  idle_cap        = 15;
  bit  valid_up        = 1'b0;

  initial begin
    foreach (delay_line[i]) delay_line[i] = '0;
  end

  // Advances the gate model by one sample and returns the result beat the
  // block must produce for it.
  function automatic gate_result_t run_gate(input logic signed [15:0] x);
    gate_result_t r;
    int           mag;
    int           len;
    int           target;
    int           coeff;
    longint       prod;
    longint       step_v;
    longint       y;
    logic signed [15:0] delayed;
    mag = (x < 0) ? -int'(x) : int'(x);
    len = (look_len > DELAY_DEPTH) ? DELAY_DEPTH : int'(look_len);
    // A zero lookahead bypasses the delay line; a full-depth lookahead reads
    // the very slot that is about to be overwritten.
    if (len == 0) begin
      delayed = x;
    end else begin
      delayed = delay_line[wr_slot - 12'(len)];
    end
    delay_line[wr_slot] = x;
    wr_slot = wr_slot + 12'd1;

    r.just_opened = 1'b0;
    if (gate_state) begin
      if (mag < int'(thr_close)) begin
        if (hold_cnt != HOLD_CEIL) hold_cnt = hold_cnt + 25'd1;
        if (hold_cnt > {1'b0, hold_set}) gate_state = 1'b0;
      end else begin
        hold_cnt = '0;
      end
    end else if (mag >= int'(thr_open)) begin
      gate_state    = 1'b1;
      hold_cnt      = '0;
      r.just_opened = 1'b1;
    end

    // One-pole step toward the target, its magnitude rounded up so that any
    // nonzero coefficient lands on the target in the end.
    target = gate_state ? FULL_GAIN : 0;
    coeff  = (target > gain_q15) ? int'(coeff_att) : int'(coeff_rel);
    prod   = longint'(coeff) * longint'(target - gain_q15);
    if (prod >= 0) begin
      step_v = (prod + 32767) >>> 15;
    end else begin
      step_v = -((-prod + 32767) >>> 15);
    end
    gain_q15 = gain_q15 + int'(step_v);
    if (gain_q15 < 0) gain_q15 = 0;
    if (gain_q15 > FULL_GAIN) gain_q15 = FULL_GAIN;

    // Round to nearest with ties upward, then saturate to the sample width.
    y = (longint'(delayed) * longint'(gain_q15) + 16384) >>> 15;
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;

    r.sample_out = 16'(y);
    r.gain       = 16'(gain_q15);
    r.gate_open  = gate_state;
    return r;
  endfunction

  // Turns a magnitude into a sample of random sign; the top magnitude only
  // exists as the most negative sample.
  function automatic logic signed [15:0] from_mag(input int mag);
    if (mag >= FULL_GAIN) return 16'sh8000;
    return ($urandom_range(0, 1) != 0) ? 16'(-mag) : 16'(mag);
  endfunction

  // Coefficients mostly fall in the legal range, with its ends and now and
  // then an oversized value that overshoots the target.
  function automatic logic [15:0] draw_coeff();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 16'd1;
    if (pick == 1) return 16'h8000;
    if (pick == 2) return 16'($urandom_range(32769, 65535));
    return 16'($urandom_range(1, 32768));
  endfunction

  task automatic write_reg(input lng_pkg::reg_idx_t idx, input logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    // The block latched the register at this edge; the model follows suit.
    case (idx)
      lng_pkg::REG_OPEN_THR:  thr_open  = val[15:0];
      lng_pkg::REG_CLOSE_THR: thr_close = val[15:0];
      lng_pkg::REG_ATTACK:    coeff_att = val[15:0];
      lng_pkg::REG_RELEASE:   coeff_rel = val[15:0];
      lng_pkg::REG_HOLD:      hold_set  = val;
      lng_pkg::REG_LOOKAHEAD: look_len  = val[12:0];
      default: begin
      end
    endcase
    reg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Sends one sample beat after a random gap and queues its expected result.
  // A pinned result, typed into the directed plan, replaces the model's.
  task automatic send_sample(input logic signed [15:0] s, input bit pinned,
                             input gate_result_t pin);
    int           gap;
    gate_result_t modeled;
    gap = (idle_cap == 0) ? 0 : $urandom_range(0, idle_cap);
    if (gap > 0) begin
      if (valid_up) in_valid <= 1'b0;
      valid_up = 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= s;
    valid_up = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    modeled = run_gate(s);
    gate_results_q.push_back(pinned ? pin : modeled);
    if (modeled.just_opened) opens_seen++;
    samples_sent++;
  endtask

  // Holds the sender back until every queued result has come out, leaving the
  // block idle so that registers may be written.
  task automatic settle();
    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up = 1'b0;
      @(posedge clk);
    end
    while (gate_results_q.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  // Result checker: every beat taken from the block is compared field by
  // field with the oldest expected result.
  always @(posedge clk) begin : result_check
    gate_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (gate_results_q.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual sample_out %0d gain %0d",
                 $time, sample_out, gain_now);
        errors++;
      end else begin
        want = gate_results_q.pop_front();
        check_field("sample_out", int'(want.sample_out), int'(sample_out));
        check_field("gain_now", int'(want.gain), int'(gain_now));
        check_field("gate_is_open", int'(want.gate_open), int'(gate_is_open));
        check_field("opened_now", int'(want.just_opened), int'(opened_now));
        results_checked++;
      end
    end
  end

  // Receiver: before each beat it stalls for a random number of cycles, then
  // takes the beat as soon as it shows. With idle_cap at zero it never stalls.
  initial begin : result_sink
    int hold_off;
    while (rst) @(posedge clk);
    forever begin
      hold_off = (idle_cap == 0) ? 0 : $urandom_range(0, idle_cap);
      if (hold_off > 0) begin
        out_stall <= 1'b1;
        repeat (hold_off) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: no progress after %0d cycles, %0d results still due",
               $time, CYCLE_LIMIT, gate_results_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    gate_result_t pin;
    int           sent;
    int           kind;
    int           seg_len;
    int           mag;
    int           pick;
    logic signed [15:0] s;
    logic [23:0]  look_val;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed plan. Register rows wait for the gate to drain first.
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_REG) begin
        settle();
        write_reg(DIRECTED[i].reg_sel, DIRECTED[i].reg_val);
      end else begin
        pin = '{DIRECTED[i].want_out, DIRECTED[i].want_gain, DIRECTED[i].want_open,
                DIRECTED[i].want_opened};
        send_sample(DIRECTED[i].smp, DIRECTED[i].kind == ROW_CHECKED, pin);
      end
    end

    // Random phases. Each one drains the gate (the sender waits until every
    // result is out), retunes all six registers, then plays audio-like
    // segments: loud bursts that open the gate, quiet runs that walk the hold
    // counter, samples right at a threshold, and plain noise. The first four
    // phases pin the lookahead to its extremes, including saturation.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      pick = $urandom_range(0, 9);
      write_reg(lng_pkg::REG_OPEN_THR, (pick == 0) ? 24'd0 : (pick == 1) ? 24'h8000 :
                                       24'($urandom_range(20, 6000)));
      pick = $urandom_range(0, 9);
      write_reg(lng_pkg::REG_CLOSE_THR, (pick == 0) ? 24'd0 : (pick == 1) ? 24'h8000 :
                                        24'($urandom_range(0, int'(thr_open))));
      write_reg(lng_pkg::REG_ATTACK, {8'd0, draw_coeff()});
      write_reg(lng_pkg::REG_RELEASE, {8'd0, draw_coeff()});
      pick = $urandom_range(0, 9);
      write_reg(lng_pkg::REG_HOLD, (pick == 0) ? 24'd0 : (pick == 1) ? 24'hFFFFFF :
                                   24'($urandom_range(0, 30)));
      case (phase)
        0: look_val = 24'd4096;
        1: look_val = 24'd0;
        2: look_val = 24'h1FFF;
        3: look_val = 24'd1;
        default: begin
          look_val = ($urandom_range(0, 1) != 0) ? 24'($urandom_range(0, 64)) :
                                                   24'($urandom_range(0, 8191));
        end
      endcase
      write_reg(lng_pkg::REG_LOOKAHEAD, look_val);

      // Every third phase runs both sides flat out.
      idle_cap = (phase % 3 == 2) ? 0 : 15;

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        kind = $urandom_range(0, 9);
        if (kind <= 2) begin
          seg_len = $urandom_range(1, 12);
        end else if (kind <= 5) begin
          seg_len = $urandom_range(1, (hold_set < 24'd37) ? int'(hold_set) + 3 : 40);
        end else begin
          seg_len = $urandom_range(1, 8);
        end
        for (int k = 0; k < seg_len && sent < PHASE_ITEMS; k++) begin
          if (kind <= 2) begin
            s = from_mag($urandom_range(int'(thr_open), FULL_GAIN));
          end else if (kind <= 5) begin
            s = (thr_close == 16'd0) ? 16'sd0 :
                from_mag($urandom_range(0, int'(thr_close) - 1));
          end else if (kind <= 7) begin
            mag = ($urandom_range(0, 1) != 0) ? int'(thr_open) : int'(thr_close);
            mag = mag + $urandom_range(0, 2) - 1;
            if (mag < 0) mag = 0;
            s = from_mag(mag);
          end else begin
            s = 16'($urandom);
          end
          send_sample(s, 1'b0, '0);
          sent++;
        end
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d sample beats and checked %0d result beats over %0d register writes.",
             samples_sent, results_checked, reg_writes);
    $display("The gate opened %0d times across %0d randomized settings.",
             opens_seen, RANDOM_PHASES);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/lng_pkg.sv
rtl/lng_sequencer.sv
rtl/lng_delay.sv
rtl/lng_datapath.sv
rtl/lookahead_noise_gate_top.sv
rtl/lng_checker.sv
dv/tb.sv
